// ===== src/base64_stream_encoder_defines.svh =====
// Assertion macros used by the base64 stream encoder queue
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// check a property on every rising edge outside reset
`define B64ENC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition implies a consequence in the next cycle
`define B64ENC_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/b64enc_pkg.sv =====
// Types, constants and the character map of the base64 stream encoder
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] UPPER_BASE = 8'h41;
    localparam logic [7:0] LOWER_BASE = 8'h61;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_t;

    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nvalid;
        logic        final_grp;
    } grp_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [5:0] s;
        logic [7:0] c;
        s = v & SEXTET_MASK;
        if (s < 6'd26) begin
            c = UPPER_BASE + {2'b00, s};
        end else if (s < 6'd52) begin
            c = LOWER_BASE + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = DIGIT_BASE + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = PLUS_CHAR;
        end else begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== src/b64enc_front.sv =====
// Byte gathering front end: builds 24-bit groups and pushes them to the queue
`timescale 1ns / 1ps

module b64enc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64enc_pkg::in_t     s_data,
    input  logic                q_full,
    output logic                push,
    output b64enc_pkg::grp_t    push_grp
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  phase;
    logic        accept;
    logic        emit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase = (phase_reg == 2'd3) ? 2'd0 : phase_reg;
        case (phase)
            2'd0: begin
                push_grp.word   = {s_data.data_byte, 16'h0000};
                push_grp.nvalid = 2'd1;
            end
            2'd1: begin
                push_grp.word   = {pend_reg[15:8], s_data.data_byte, 8'h00};
                push_grp.nvalid = 2'd2;
            end
            default: begin
                push_grp.word   = {pend_reg, s_data.data_byte};
                push_grp.nvalid = 2'd3;
            end
        endcase
        push_grp.final_grp = s_data.end_of_input;
        emit = (push_grp.nvalid == 2'd3) || s_data.end_of_input;
        push = accept && emit;

        pend_next  = pend_reg;
        phase_next = phase_reg;
        if (accept) begin
            if (emit) begin
                pend_next  = 16'h0000;
                phase_next = 2'd0;
            end else begin
                if (phase == 2'd0) begin
                    pend_next = {s_data.data_byte, 8'h00};
                end else begin
                    pend_next = {pend_reg[15:8], s_data.data_byte};
                end
                phase_next = phase + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 16'h0000;
            phase_reg <= 2'd0;
        end else begin
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== src/b64enc_queue.sv =====
// Short group queue between the front end and the character back end
`timescale 1ns / 1ps
`include "base64_stream_encoder_defines.svh"

module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  b64enc_pkg::grp_t    push_grp,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output b64enc_pkg::grp_t    head_grp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64enc_pkg::grp_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_grp   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `B64ENC_ASSERT(a_cnt_bound, cnt_reg <= FULL_CNT, "queue count beyond depth")
    `B64ENC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "missed push")
    `B64ENC_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "missed pop")
    `B64ENC_ASSERT_NEXT(a_rd_hold, !pop, $stable(rd_ptr_reg), "read pointer moved without pop")
    `B64ENC_ASSERT_NEXT(a_wr_hold, !push, $stable(wr_ptr_reg), "write pointer moved without push")

endmodule

// ===== src/b64enc_back.sv =====
// Character back end: serializes each group into four characters
`timescale 1ns / 1ps

module b64enc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  b64enc_pkg::grp_t    head_grp,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output b64enc_pkg::out_t    m_data
);

    logic [1:0]        idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    b64enc_pkg::out_t  m_data_reg, m_data_next;
    logic              load;
    logic [5:0]        sextet;

    assign load    = !m_valid_reg || m_ready;
    assign pop     = load && head_valid && (idx_reg == 2'd3);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        case (idx_reg)
            2'd0:    sextet = head_grp.word[23:18];
            2'd1:    sextet = head_grp.word[17:12];
            2'd2:    sextet = head_grp.word[11:6];
            default: sextet = head_grp.word[5:0];
        endcase

        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = head_valid;
            if (head_valid) begin
                m_data_next.out_char  = (idx_reg <= head_grp.nvalid)
                                        ? b64enc_pkg::sextet_to_char(sextet)
                                        : b64enc_pkg::PAD_CHAR;
                m_data_next.last_char = head_grp.final_grp && (idx_reg == 2'd3);
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/base64_stream_encoder.sv =====
// Flow: the edge accepting a group's last byte writes it to the queue; its first character is
// registered from the queue head into the output register. Throughput: one input byte per cycle
// until the two-entry group queue fills; one character per cycle from the single output register
// while m_ready is high; four characters per three bytes; two groups of slack between the sides.
// Reset: synchronous active-low aresetn clears phase, queue and output valid.
// Top level of the streaming base64 encoder
`timescale 1ns / 1ps

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64enc_pkg::in_t     s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64enc_pkg::out_t    m_data
);

    logic              q_full;
    logic              push;
    b64enc_pkg::grp_t  push_grp;
    logic              pop;
    logic              head_valid;
    b64enc_pkg::grp_t  head_grp;

    b64enc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_grp (push_grp)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_grp   (push_grp),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_grp   (head_grp)
    );

    b64enc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_grp   (head_grp),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the base64 stream encoder: bytes in, predicted characters checked
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT      = 200000;
    localparam int HOLD_OFF   = 300;
    localparam int TAIL_WAIT  = 20;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    b64enc_pkg::in_t  s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    b64enc_pkg::out_t m_data;

    b64enc_pkg::in_t  byte_q[$];
    b64enc_pkg::out_t char_q[$];

    logic [15:0] held_bytes  = '0;
    logic [1:0]  group_phase = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int cycle_count   = 0;

    base64_stream_encoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 6'd26) begin
            return b64enc_pkg::UPPER_BASE + 8'(s);
        end else if (s < 6'd52) begin
            return b64enc_pkg::LOWER_BASE + 8'(s - 6'd26);
        end else if (s < 6'd62) begin
            return b64enc_pkg::DIGIT_BASE + 8'(s - 6'd52);
        end else if (s == 6'd62) begin
            return b64enc_pkg::PLUS_CHAR;
        end
        return b64enc_pkg::SLASH_CHAR;
    endfunction

    task automatic encode_byte(input b64enc_pkg::in_t it);
        logic [23:0]      word;
        int               nreal;
        int               k;
        b64enc_pkg::out_t c;
        if (group_phase == 2'd3) begin
            group_phase = 2'd0;
        end
        case (group_phase)
            2'd0: begin
                word  = {it.data_byte, 16'h0000};
                nreal = 1;
            end
            2'd1: begin
                word  = {held_bytes[15:8], it.data_byte, 8'h00};
                nreal = 2;
            end
            default: begin
                word  = {held_bytes, it.data_byte};
                nreal = 3;
            end
        endcase
        if (nreal == 3 || it.end_of_input) begin
            for (k = 0; k < 4; k++) begin
                c.out_char  = (k <= nreal)
                              ? sextet_char(6'(word >> (18 - 6 * k)))
                              : b64enc_pkg::PAD_CHAR;
                c.last_char = it.end_of_input && (k == 3);
                char_q.push_back(c);
            end
            held_bytes  = '0;
            group_phase = 2'd0;
        end else begin
            if (group_phase == 2'd0) begin
                held_bytes = {it.data_byte, 8'h00};
            end else begin
                held_bytes[7:0] = it.data_byte;
            end
            group_phase = group_phase + 2'd1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_byte(s_data);
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= byte_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        b64enc_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected transfer: out_char %h last_char %b",
                           m_data.out_char, m_data.last_char);
                    errors++;
                end else begin
                    want = char_q.pop_front();
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h", want.out_char, m_data.out_char);
                        errors++;
                    end
                    if (m_data.last_char !== want.last_char) begin
                        $error("last_char: expected %b, got %b",
                               want.last_char, m_data.last_char);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        b64enc_pkg::in_t it;
        it.data_byte    = b;
        it.end_of_input = fin;
        byte_q.push_back(it);
    endtask

    task automatic push_message(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic push_random(input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9) == 0) begin
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                n++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
                push_message(len);
                n += len;
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (byte_q.size() != 0 || s_valid || char_q.size() != 0);
    endtask

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-byte messages, both padding lengths, full groups, plus and slash
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFB, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBE, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h6E, 1'b0);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h61, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_drained();

        send_idle_pct = 27;
        recv_idle_pct = 49;
        push_random(100);
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct = 27;
        push_random(100);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        push_random(100);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
